// ----- rtl/tlb_fifo_replacement_core_macros.svh -----
// Assertion macros for the translation buffer core.
`ifndef TLB_FIFO_REPLACEMENT_CORE_MACROS_SVH
`define TLB_FIFO_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLBF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlbf assertion failed");

// Next-cycle implication, disabled during reset.
`define TLBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlbf assertion failed");

`endif

// ----- rtl/tlbf_pkg.sv -----
// Shared types and constants for the translation buffer core.
`default_nettype none
package tlbf_pkg;

    localparam int PAGE_BITS  = 8;
    localparam int FRAME_BITS = 8;
    localparam int COUNT_BITS = 5;
    localparam int HIT_BITS   = 32;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [PAGE_BITS-1:0]  page_number;
        logic [FRAME_BITS-1:0] frame_number;
    } t_tlb_in;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_out;
        logic                  evicted;
        logic [PAGE_BITS-1:0]  evicted_page;
        logic [COUNT_BITS-1:0] entry_count;
        logic [HIT_BITS-1:0]   hit_total;
    } t_tlb_out;

    typedef struct packed {
        logic capture;
        logic match;
        logic commit;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ----- rtl/tlb_fifo_replacement_core.sv -----
// Top level of the fully associative translation buffer with FIFO replacement.
// Input channel: i_in_valid / o_in_stall carry one request beat (opcode, page,
// frame). Opcodes: lookup, add, remove; the unused code only reports state.
// Output channel: o_out_valid / i_out_stall carry one result beat per request.
// Each request passes the parallel compare of all entries in the match state and
// then the commit that updates entries, age order and counters.
// The next request is taken in the commit cycle, so a held result does not
// block intake; while the receiver stalls with a result pending, the commit of
// the following request waits and the input stalls.
// Reset clears all valid flags, the entry count and the hit counter; no
// clearing pass is needed, so requests are taken right after reset.
`default_nettype none
`include "tlb_fifo_replacement_core_macros.svh"
module tlb_fifo_replacement_core #(
    parameter int ENTRIES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tlbf_pkg::t_tlb_in  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tlbf_pkg::t_tlb_out      o_out_data
);
    import tlbf_pkg::*;

    t_dp_cmd cmd;

    tlbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    tlbf_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_data),
        .o_res   (o_out_data)
    );

    `TLBF_ASSERT_NEXT(a_no_back_to_back, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `TLBF_ASSERT_NOW(a_evict_when_full, i_clk, i_rst_n, o_out_valid && o_out_data.evicted, !o_out_data.hit && (int'(o_out_data.entry_count) == ENTRIES))
    `TLBF_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_out_valid, int'(o_out_data.entry_count) <= ENTRIES)
endmodule
`default_nettype wire

// ----- rtl/tlbf_ctrl.sv -----
// Control state machine: sequences capture, match and commit of each beat.
`default_nettype none
module tlbf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_stall,
    output tlbf_pkg::t_dp_cmd     o_cmd,
    output logic                  o_in_stall,
    output logic                  o_out_valid
);
    import tlbf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   commit;
    logic   capture;

    always_comb begin
        commit       = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
        o_in_stall   = !((r_state == ST_IDLE) || commit);
        capture      = i_in_valid && !o_in_stall;
        o_cmd.capture = capture;
        o_cmd.match   = (r_state == ST_MATCH);
        o_cmd.commit  = commit;
        o_out_valid   = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (capture) begin
                        r_state <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (commit) begin
                        r_state <= capture ? ST_MATCH : ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/tlbf_dp.sv -----
// Datapath: entry store, parallel match, age order and result register.
`default_nettype none
module tlbf_dp #(
    parameter int ENTRIES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tlbf_pkg::t_dp_cmd i_cmd,
    input  wire tlbf_pkg::t_tlb_in i_req,
    output tlbf_pkg::t_tlb_out     o_res
);
    import tlbf_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [PAGE_BITS-1:0]  r_page_arr  [ENTRIES];
    logic [FRAME_BITS-1:0] r_frame_arr [ENTRIES];
    logic [IW-1:0]         r_age       [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [CW-1:0]         r_count;
    logic [HIT_BITS-1:0]   r_hits;
    t_tlb_in               r_req;
    t_tlb_out              r_out;

    logic                  r_lk_found;
    logic [IW-1:0]         r_lk_idx;
    logic                  r_rm_found;
    logic [IW-1:0]         r_rm_idx;
    logic [IW-1:0]         r_free_idx;

    // match stage
    logic                  lk_found;
    logic [IW-1:0]         lk_idx;
    logic                  rm_found;
    logic [IW-1:0]         rm_idx;
    logic [IW-1:0]         free_idx;

    always_comb begin
        lk_found = 1'b0;
        lk_idx   = '0;
        rm_found = 1'b0;
        rm_idx   = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_page_arr[i] == r_req.page_number)) begin
                lk_found = 1'b1;
                lk_idx   = IW'(i);
                if (r_frame_arr[i] == r_req.frame_number) begin
                    rm_found = 1'b1;
                    rm_idx   = IW'(i);
                end
            end
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    // commit stage
    logic                  full;
    logic                  is_lookup;
    logic                  is_add;
    logic                  is_remove;
    logic [IW-1:0]         evict_slot;
    logic [IW-1:0]         wr_slot;
    logic [ENTRIES-1:0]    shift_vec;
    logic                  seen;
    logic [CW-1:0]         n_count;
    logic [HIT_BITS-1:0]   n_hits;
    t_tlb_out              n_out;

    always_comb begin
        full       = (r_count == CW'(ENTRIES));
        is_lookup  = (r_req.opcode == OP_LOOKUP);
        is_add     = (r_req.opcode == OP_ADD);
        is_remove  = (r_req.opcode == OP_REMOVE);
        evict_slot = r_age[0];
        wr_slot    = full ? evict_slot : r_free_idx;
        seen       = 1'b0;
        for (int k = 0; k < ENTRIES; k++) begin
            if ((r_age[k] == r_rm_idx) && (CW'(k) < r_count)) begin
                seen = 1'b1;
            end
            shift_vec[k] = seen && ((CW'(k) + CW'(1)) < r_count);
        end
        n_count = r_count;
        n_hits  = r_hits;
        if (is_lookup && r_lk_found) begin
            n_hits = r_hits + HIT_BITS'(1);
        end
        if (is_add && !full) begin
            n_count = r_count + CW'(1);
        end
        if (is_remove && r_rm_found) begin
            n_count = r_count - CW'(1);
        end
        n_out.hit          = (is_lookup && r_lk_found) || (is_remove && r_rm_found);
        n_out.frame_out    = (is_lookup && r_lk_found) ? r_frame_arr[r_lk_idx] : '0;
        n_out.evicted      = is_add && full;
        n_out.evicted_page = (is_add && full) ? r_page_arr[evict_slot] : '0;
        n_out.entry_count  = COUNT_BITS'(n_count);
        n_out.hit_total    = n_hits;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.match) begin
            r_lk_found <= lk_found;
            r_lk_idx   <= lk_idx;
            r_rm_found <= rm_found;
            r_rm_idx   <= rm_idx;
            r_free_idx <= free_idx;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
            if (is_add) begin
                r_page_arr[wr_slot]  <= r_req.page_number;
                r_frame_arr[wr_slot] <= r_req.frame_number;
            end
            for (int k = 0; k < ENTRIES; k++) begin
                if (is_add && !full && (CW'(k) == r_count)) begin
                    r_age[k] <= r_free_idx;
                end
                if (is_add && full) begin
                    r_age[k] <= (k == ENTRIES - 1) ? evict_slot
                                                   : r_age[(k + 1) % ENTRIES];
                end
                if (is_remove && r_rm_found && shift_vec[k]) begin
                    r_age[k] <= r_age[(k + 1) % ENTRIES];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_hits  <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
            r_hits  <= n_hits;
            if (is_add) begin
                r_valid[wr_slot] <= 1'b1;
            end
            if (is_remove && r_rm_found) begin
                r_valid[r_rm_idx] <= 1'b0;
            end
        end
    end

    assign o_res = r_out;
endmodule
`default_nettype wire

// ----- bench/tlb_result_monitor.sv -----
// Result monitor for the translation buffer: tracks buffer contents and checks each result beat.
module tlb_result_monitor #(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  tlbf_pkg::t_tlb_in  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  tlbf_pkg::t_tlb_out i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tlbf_pkg::*;

    logic [PAGE_BITS-1:0]  slot_page  [ENTRIES];
    logic [FRAME_BITS-1:0] slot_frame [ENTRIES];
    logic                  slot_valid [ENTRIES];
    int                    fifo_order [ENTRIES];
    int                    live_count;
    logic [HIT_BITS-1:0]   hit_count;
    t_tlb_out              expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic translate(input t_tlb_in req, output t_tlb_out res);
        int slot;
        int pos;
        res = '0;
        slot = -1;
        pos = -1;
        case (req.opcode)
            OP_LOOKUP: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && slot_valid[i] && slot_page[i] == req.page_number)
                        slot = i;
                if (slot >= 0) begin
                    res.hit = 1'b1;
                    res.frame_out = slot_frame[slot];
                    hit_count = hit_count + HIT_BITS'(1);
                end
            end
            OP_ADD: begin
                if (live_count < ENTRIES) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !slot_valid[i])
                            slot = i;
                    slot_valid[slot] = 1'b1;
                    fifo_order[live_count] = slot;
                    live_count++;
                end else begin
                    slot = fifo_order[0];
                    res.evicted = 1'b1;
                    res.evicted_page = slot_page[slot];
                    for (int k = 0; k + 1 < ENTRIES; k++)
                        fifo_order[k] = fifo_order[k + 1];
                    fifo_order[ENTRIES - 1] = slot;
                end
                slot_page[slot] = req.page_number;
                slot_frame[slot] = req.frame_number;
            end
            OP_REMOVE: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && slot_valid[i] && slot_page[i] == req.page_number &&
                        slot_frame[i] == req.frame_number)
                        slot = i;
                if (slot >= 0) begin
                    res.hit = 1'b1;
                    for (int k = 0; k < live_count; k++)
                        if (pos < 0 && fifo_order[k] == slot)
                            pos = k;
                    for (int k = pos; k + 1 < live_count; k++)
                        fifo_order[k] = fifo_order[k + 1];
                    slot_valid[slot] = 1'b0;
                    live_count--;
                end
            end
            default: ;
        endcase
        res.entry_count = live_count[COUNT_BITS-1:0];
        res.hit_total = hit_count;
    endtask

    task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tlb_out want;
        t_tlb_out next_res;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_page[i] = '0;
                slot_frame[i] = '0;
                fifo_order[i] = 0;
            end
            live_count = 0;
            hit_count = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, i_out_data);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    flag("hit", 32'(want.hit), 32'(i_out_data.hit));
                    flag("frame_out", 32'(want.frame_out), 32'(i_out_data.frame_out));
                    flag("evicted", 32'(want.evicted), 32'(i_out_data.evicted));
                    flag("evicted_page", 32'(want.evicted_page),
                         32'(i_out_data.evicted_page));
                    flag("entry_count", 32'(want.entry_count),
                         32'(i_out_data.entry_count));
                    flag("hit_total", want.hit_total, i_out_data.hit_total);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                translate(i_in_data, next_res);
                expected_results.push_back(next_res);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the translation buffer core: clock, reset, request stimulus and verdict.
module tb;
    import tlbf_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ENTRIES = 16;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PHASES = 9;
    localparam int HISTORY_DEPTH = 24;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_tlb_in  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_tlb_out out_data;
    int       fail_count;
    int       pending;
    bit       calm = 1'b0;
    int       stall_run = 0;
    t_tlb_in  recent_pairs [$];

    always #5 clk = ~clk;

    tlb_fifo_replacement_core #(.ENTRIES(ENTRIES)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    tlb_result_monitor #(.ENTRIES(ENTRIES)) u_result_monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_tlb_in tlb_req(input logic [1:0] op, input logic [7:0] page,
                                        input logic [7:0] frame);
        t_tlb_in r;
        r.opcode = op;
        r.page_number = page;
        r.frame_number = frame;
        return r;
    endfunction

    // add_pct / remove_pct steer the fill level; the rest are lookups and unused codes
    function automatic t_tlb_in random_req(input int add_pct, input int remove_pct);
        t_tlb_in r;
        t_tlb_in known;
        int pick;
        pick = $urandom_range(0, 99);
        r.page_number = PAGE_BITS'($urandom());
        r.frame_number = FRAME_BITS'($urandom());
        if (pick < 4)
            r.opcode = OP_UNUSED;
        else if (pick < 4 + add_pct)
            r.opcode = OP_ADD;
        else if (pick < 4 + add_pct + remove_pct)
            r.opcode = OP_REMOVE;
        else
            r.opcode = OP_LOOKUP;
        if (r.opcode == OP_ADD) begin
            if ($urandom_range(0, 99) < 40)
                r.page_number = PAGE_BITS'($urandom_range(0, 11));
        end else if (recent_pairs.size() > 0 && $urandom_range(0, 99) < 70) begin
            known = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
            r.page_number = known.page_number;
            if ($urandom_range(0, 99) < 80)
                r.frame_number = known.frame_number;
        end
        return r;
    endfunction

    task automatic send_req(input t_tlb_in req);
        int gap;
        bit taken;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        taken = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = !in_stall;
            @(negedge clk);
        end
        if (req.opcode == OP_ADD) begin
            if (recent_pairs.size() >= HISTORY_DEPTH)
                void'(recent_pairs.pop_front());
            recent_pairs.push_back(req);
        end
    endtask

    // receiver stall bursts
    always @(negedge clk) begin
        if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run = stall_run - 1;
        end else begin
            out_stall <= 1'b0;
            stall_run = calm ? 0 : pick_gap();
        end
    end

    initial begin
        int add_pct;
        int remove_pct;
        int wait_cycles;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_req(tlb_req(OP_LOOKUP, 8'h00, 8'h00));
        send_req(tlb_req(OP_UNUSED, 8'hff, 8'hff));
        send_req(tlb_req(OP_REMOVE, 8'h00, 8'h00));
        send_req(tlb_req(OP_ADD, 8'hff, 8'hff));
        send_req(tlb_req(OP_ADD, 8'h00, 8'h00));
        send_req(tlb_req(OP_ADD, 8'haa, 8'h55));
        send_req(tlb_req(OP_ADD, 8'haa, 8'h33));
        send_req(tlb_req(OP_LOOKUP, 8'hff, 8'h00));
        send_req(tlb_req(OP_LOOKUP, 8'haa, 8'hff));
        send_req(tlb_req(OP_REMOVE, 8'haa, 8'h99));
        send_req(tlb_req(OP_REMOVE, 8'haa, 8'h55));
        send_req(tlb_req(OP_LOOKUP, 8'haa, 8'h00));
        send_req(tlb_req(OP_ADD, 8'h55, 8'haa));
        for (int i = 0; i < 12; i++)
            send_req(tlb_req(OP_ADD, 8'h10 + i[7:0], 8'hf0 - i[7:0]));
        send_req(tlb_req(OP_ADD, 8'h80, 8'h01));
        send_req(tlb_req(OP_ADD, 8'h81, 8'h02));

        for (int p = 0; p < PHASES; p++) begin
            calm = (p % 4 == 3);
            case (p % 3)
                0: begin add_pct = 55; remove_pct = 10; end
                1: begin add_pct = 15; remove_pct = 50; end
                default: begin add_pct = 30; remove_pct = 25; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_req(random_req(add_pct, remove_pct));
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 5000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
